// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define G2L_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true.
`define G2L_ASSERT_NEVER(name, cond, msg) \
  `G2L_ASSERT(name, !(cond), msg)

`endif

// ----- hdl/g2l_pkg.sv -----
// ----------------------------------------------------------------------------
// g2l_pkg
// Types, year table and calendar constants for the lunar date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package g2l_pkg;

  localparam int unsigned TableYears = 199;
  localparam int unsigned IdxW       = $clog2(TableYears);
  localparam int unsigned WordW      = 24;

  localparam logic [11:0] FirstYear = 12'd1901;
  localparam logic [11:0] LastYear  = 12'd2099;

  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } req_t;

  typedef struct packed {
    logic       valid_res;
    logic [4:0] lunar_century;
    logic [6:0] lunar_year_low;
    logic [3:0] lunar_month;
    logic [4:0] lunar_day;
  } res_t;

  // decoded request
  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] idx;
    logic [8:0]      doy;
    logic [4:0]      cent;
    logic [6:0]      low;
  } prep_t;

  // table RAM write port
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  addr;
    logic [WordW-1:0] data;
  } ram_wr_t;

  localparam logic [8:0] DaysBefore [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // [23:20] leap month, [19:7] month lengths, [6:5] new-year month, [4:0] day
  localparam logic [WordW-1:0] YearInfo [TableYears] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544, 24'h46AAB9,
    24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A, 24'h6A4DBE, 24'h0A4D52,
    24'h0D2546, 24'h5D52BA, 24'h0B544E, 24'h0D6A43, 24'h296D37, 24'h095B4B,
    24'h749BC1, 24'h049754, 24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445,
    24'h4ADAB8, 24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
    24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644, 24'h393738,
    24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48, 24'h6DA53B, 24'h0B554F,
    24'h056A45, 24'h4AADB9, 24'h025D4D, 24'h092D42, 24'h2C95B6, 24'h0A954A,
    24'h7B4ABD, 24'h06CA51, 24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43,
    24'h352BB8, 24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h7AD53C,
    24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642, 24'h3E9335,
    24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46, 24'h54AEBB, 24'h04AD4F,
    24'h0A4D43, 24'h4D26B7, 24'h0D254B, 24'h8D52BF, 24'h0B5452, 24'h0B6A47,
    24'h696D3C, 24'h095B50, 24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2,
    24'h06A554, 24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
    24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF, 24'h05AC53,
    24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645, 24'h4D4AB8, 24'h0D4A4C,
    24'h0DA541, 24'h25AAB6, 24'h056A49, 24'h7AADBD, 24'h025D52, 24'h092D47,
    24'h5C95BA, 24'h0A954E, 24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF,
    24'h04BA53, 24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D, 24'h0A4E51,
    24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43, 24'h36B537, 24'h096D4B,
    24'hB4AEBF, 24'h04AD53, 24'h0A4D48, 24'h6D25BC, 24'h0D254F, 24'h0D5244,
    24'h5DAA38, 24'h0B5A4C, 24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE,
    24'h0A4B51, 24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C, 24'h0EA54F,
    24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42, 24'h3C9735, 24'h0C9649,
    24'h7D4ABD, 24'h0D4A51, 24'h0DA545, 24'h55AABA, 24'h056A4E, 24'h0A6D43,
    24'h452EB7, 24'h052D4B, 24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B,
    24'h0AD54F, 24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA, 24'h04B64E,
    24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E, 24'h0D5252, 24'h0DAA47,
    24'h66B53B, 24'h056D4F, 24'h04AE45, 24'h4A4EB9, 24'h0A4D4C, 24'h0D1541,
    24'h2D92B5
  };

endpackage

`default_nettype wire

// ----- hdl/gregorian_to_lunar_date_unit.sv -----
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_unit
// Gregorian to Chinese lunar date conversion for years 1901 to 2099.
// ----------------------------------------------------------------------------
// After reset the unit copies its 199-entry year table into RAM, one word a
// cycle, and holds in_ready_o low until the copy is done. A request then
// goes through these steps: the year word is read; the previous year's word
// is read when the date lies before lunar new year; the month sequencer
// tests one lunar month at a time, forward from new year or walking back
// from the previous year's end; and the output register is loaded, after
// which the unit is ready for the next request. A rejected date goes
// straight to the output register. A 1901 date before new year goes there
// after the year word read. One request is in flight at a time. A finished
// result waits in the output register while the next request is taken. The
// next result stalls until that register is read. Dates outside 1901..2099,
// an invalid month or day zero, and 1901 dates before new year return
// valid_res = 0 with all other fields zero. A leap month repeats its month
// number.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_to_lunar_date_unit
  import g2l_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      res_o
);

  prep_t            prep;
  ram_wr_t          ram_wr;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;

  g2l_prep u_prep (
    .req_i  (req_i),
    .prep_o (prep)
  );

  g2l_ram #(
    .Width (WordW),
    .Depth (TableYears)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  g2l_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .prep_i      (prep),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- hdl/g2l_ram.sv -----
// ----------------------------------------------------------------------------
// g2l_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module g2l_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/g2l_prep.sv -----
// ----------------------------------------------------------------------------
// g2l_prep
// Range check, table index, day of year and century split of a request.
// ----------------------------------------------------------------------------
`default_nettype none

module g2l_prep
  import g2l_pkg::*;
(
  input  wire req_t  req_i,
  output prep_t      prep_o
);

  logic        year_ok;
  logic        month_ok;
  logic [3:0]  mon_idx;
  logic        leap_adj;
  logic        upper;
  logic [11:0] year_off;
  logic [11:0] cent_base;

  always_comb begin
    year_ok   = (req_i.greg_year >= FirstYear) && (req_i.greg_year <= LastYear);
    month_ok  = (req_i.greg_month >= 4'd1) && (req_i.greg_month <= 4'd12);
    mon_idx   = month_ok ? (req_i.greg_month - 4'd1) : 4'd0;
    leap_adj  = (req_i.greg_month > 4'd2) && (req_i.greg_year[1:0] == 2'b00);
    upper     = req_i.greg_year >= 12'd2000;
    cent_base = upper ? 12'd2000 : 12'd1900;
    year_off  = req_i.greg_year - FirstYear;

    prep_o.ok   = year_ok && month_ok && (req_i.greg_day != 5'd0);
    prep_o.idx  = prep_o.ok ? year_off[IdxW-1:0] : '0;
    prep_o.doy  = DaysBefore[mon_idx] + {4'b0, req_i.greg_day} - 9'd1 + {8'b0, leap_adj};
    prep_o.cent = upper ? 5'd20 : 5'd19;
    prep_o.low  = 7'(req_i.greg_year - cent_base);
  end

endmodule

`default_nettype wire

// ----- hdl/g2l_walk.sv -----
// ----------------------------------------------------------------------------
// g2l_walk
// Table load sequencer and lunar month walker with output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module g2l_walk
  import g2l_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire prep_t            prep_i,
  output ram_wr_t               ram_wr_o,
  output logic [IdxW-1:0]       ram_raddr_o,
  input  wire logic [WordW-1:0] ram_rdata_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output res_t                  res_o
);

  typedef enum logic [2:0] {
    S_FILL, S_IDLE, S_LOOK, S_PREV, S_FWD, S_BWD, S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [IdxW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [8:0]       doy_q, doy_d;
  logic [4:0]       cent_q, cent_d;
  logic [6:0]       low_q, low_d;
  logic [WordW-1:0] word_q, word_d;
  logic [8:0]       rem_q, rem_d;
  logic [4:0]       slot_q, slot_d;
  logic [3:0]       mon_q, mon_d;
  logic             flag_q, flag_d;
  res_t             fin_q, fin_d;
  res_t             res_q, res_d;
  logic             out_valid_q, out_valid_d;

  logic [4:0] bpos;
  logic       long_mon;
  logic [4:0] len;
  logic [3:0] leap;
  logic [3:0] mon_back;
  logic [7:0] ny_jan;
  logic [8:0] ny;
  logic [3:0] prev_leap;

  always_comb begin
    bpos      = 5'd20 - slot_q;
    long_mon  = (slot_q >= 5'd1) && (slot_q <= 5'd13) && word_q[bpos];
    len       = 5'd29 + {4'b0, long_mon};
    leap      = word_q[23:20];
    mon_back  = flag_q ? mon_q : (mon_q - 4'd1);
    ny_jan    = {3'b0, ram_rdata_i[4:0]} + 8'hFF;
    ny        = (ram_rdata_i[6:5] == 2'd1) ? {1'b0, ny_jan}
                                           : ({4'b0, ram_rdata_i[4:0]} + 9'd30);
    prev_leap = ram_rdata_i[23:20];
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    doy_d       = doy_q;
    cent_d      = cent_q;
    low_d       = low_q;
    word_d      = word_q;
    rem_d       = rem_q;
    slot_d      = slot_q;
    mon_d       = mon_q;
    flag_d      = flag_q;
    fin_d       = fin_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;

    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = fill_q;
    ram_wr_o.data = YearInfo[fill_q];
    ram_raddr_o   = prep_i.idx;
    if (state_q == S_LOOK) begin
      ram_raddr_o = (idx_q == '0) ? '0 : (idx_q - IdxW'(1));
    end
    in_ready_o = (state_q == S_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_FILL: begin
        ram_wr_o.we = 1'b1;
        if (fill_q == IdxW'(TableYears - 1)) begin
          state_d = S_IDLE;
        end else begin
          fill_d = fill_q + IdxW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d  = prep_i.idx;
          doy_d  = prep_i.doy;
          cent_d = prep_i.cent;
          low_d  = prep_i.low;
          if (prep_i.ok) begin
            state_d = S_LOOK;
          end else begin
            fin_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_LOOK: begin
        word_d = ram_rdata_i;
        flag_d = 1'b0;
        if (doy_q >= ny) begin
          rem_d   = doy_q - ny;
          slot_d  = 5'd1;
          mon_d   = 4'd1;
          state_d = S_FWD;
        end else if (idx_q == '0) begin
          fin_d   = '0;
          state_d = S_DONE;
        end else begin
          rem_d = ny - doy_q;
          if (low_q == 7'd0) begin
            low_d  = 7'd99;
            cent_d = 5'd19;
          end else begin
            low_d = low_q - 7'd1;
          end
          state_d = S_PREV;
        end
      end
      S_PREV: begin
        word_d  = ram_rdata_i;
        slot_d  = (prev_leap == 4'd0) ? 5'd12 : 5'd13;
        mon_d   = 4'd12;
        state_d = S_BWD;
      end
      S_FWD: begin
        if (rem_q >= {4'b0, len}) begin
          rem_d  = rem_q - {4'b0, len};
          slot_d = slot_q + 5'd1;
          if (mon_q == leap) begin
            flag_d = !flag_q;
            if (flag_q) begin
              mon_d = mon_q + 4'd1;
            end
          end else begin
            mon_d = mon_q + 4'd1;
          end
        end else begin
          fin_d.valid_res      = 1'b1;
          fin_d.lunar_century  = cent_q;
          fin_d.lunar_year_low = low_q;
          fin_d.lunar_month    = mon_q;
          fin_d.lunar_day      = rem_q[4:0] + 5'd1;
          state_d              = S_DONE;
        end
      end
      S_BWD: begin
        if (rem_q > {4'b0, len}) begin
          rem_d  = rem_q - {4'b0, len};
          slot_d = slot_q - 5'd1;
          mon_d  = mon_back;
          if (mon_back == leap) begin
            flag_d = !flag_q;
          end
        end else begin
          fin_d.valid_res      = 1'b1;
          fin_d.lunar_century  = cent_q;
          fin_d.lunar_year_low = low_q;
          fin_d.lunar_month    = mon_q;
          fin_d.lunar_day      = len - rem_q[4:0] + 5'd1;
          state_d              = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          res_d       = fin_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_o = out_valid_q;
    res_o       = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      fill_q      <= '0;
      idx_q       <= '0;
      doy_q       <= '0;
      cent_q      <= '0;
      low_q       <= '0;
      word_q      <= '0;
      rem_q       <= '0;
      slot_q      <= '0;
      mon_q       <= '0;
      flag_q      <= 1'b0;
      fin_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      doy_q       <= doy_d;
      cent_q      <= cent_d;
      low_q       <= low_d;
      word_q      <= word_d;
      rem_q       <= rem_d;
      slot_q      <= slot_d;
      mon_q       <= mon_d;
      flag_q      <= flag_d;
      fin_q       <= fin_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  `G2L_ASSERT(a_day_range, state_q == S_DONE && fin_q.valid_res |-> fin_q.lunar_day != 5'd0 && fin_q.lunar_day <= 5'd30 && fin_q.lunar_month != 4'd0, "converted date out of range")
  `G2L_ASSERT(a_fail_zero, out_valid_q && !res_q.valid_res |-> res_q == '0, "failed result carries nonzero fields")
  `G2L_ASSERT_NEVER(a_slot_zero, (state_q == S_FWD || state_q == S_BWD) && slot_q == 5'd0, "month walk left slot range")

endmodule

`default_nettype wire
